[hdl/bbitr_pkg.sv]
// Shared types, codes and constants of the baseband interrupt and timing register block.
`default_nettype none

package bbitr_pkg;

  // Event kinds carried by one input beat.
  typedef enum logic [2:0] {
    KIND_GWRITE    = 3'd0,
    KIND_GREAD     = 3'd1,
    KIND_CFG_WRITE = 3'd2,
    KIND_ACQ_START = 3'd3,
    KIND_TICK      = 3'd4
  } kind_e;

  // Global register selects.
  typedef enum logic [3:0] {
    REG_ENABLE      = 4'd0,
    REG_RESET       = 4'd1,
    REG_FIFO_CLEAR  = 4'd2,
    REG_TRACK_START = 4'd3,
    REG_MEAS_NUM    = 4'd4,
    REG_MEAS_COUNT  = 4'd5,
    REG_FLAGS       = 4'd6,
    REG_REQUEST     = 4'd7,
    REG_MASK        = 4'd8
  } reg_sel_e;

  // Bit positions of the pending interrupt flags.
  localparam int unsigned FLAG_TRACK = 0;
  localparam int unsigned FLAG_MEAS  = 1;
  localparam int unsigned FLAG_REQ   = 2;
  localparam int unsigned FLAG_ACQ   = 3;

  // Configuration word indexes that are kept.
  localparam logic [2:0] CFG_WORD_CODE = 3'd0;
  localparam logic [2:0] CFG_WORD_SPAN = 3'd2;

  // Acquisition time arithmetic.
  localparam int unsigned CLOCK_MHZ = 100;
  localparam int unsigned BLOCK_US  = 1000;
  localparam int unsigned ACC_W     = 35;   // sum over up to 128 channels
  localparam int unsigned UNIT_W    = 10;
  localparam int unsigned NUM_W     = ACC_W + UNIT_W;
  localparam int unsigned DIV_W     = 17;
  localparam int unsigned P1_W      = 13;   // coherent times non-coherent
  localparam int unsigned P2_W      = 11;   // stride times span
  localparam int unsigned T_W       = 16;   // one plus six times P1
  localparam int unsigned PROD_W    = P2_W + T_W;
  localparam logic [UNIT_W-1:0] CYC_PER_UNIT = 10'd682;
  localparam logic [DIV_W-1:0]  CLK_PER_BLOCK = DIV_W'(CLOCK_MHZ * BLOCK_US);

  // Division by the clocks per block: each quotient digit takes an estimate step, then a remainder step.
  // The digit estimate multiplies the partial dividend by the reciprocal
  // ceil(2^43 / 100000), which is exact for every partial dividend below
  // 100000 * 512.
  localparam int unsigned DIG_W     = 9;
  localparam int unsigned DIGITS    = NUM_W / DIG_W;
  localparam int unsigned PART_W    = DIV_W + DIG_W;
  localparam int unsigned RECIP_W   = 27;
  localparam int unsigned RECIP_SH  = 43;
  localparam int unsigned EST_W     = PART_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = 27'd87960931;
  localparam int unsigned DIG_CNT_W = 3;
  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(DIGITS - 1);

  // Micro-operations of the acquisition datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_READ,
    OP_MULA,
    OP_MULB,
    OP_ACC,
    OP_SCALE,
    OP_DIV_EST,
    OP_DIV_REM,
    OP_FINISH
  } uop_e;

  // Jump conditions of the sequencer.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_IDX_END,
    COND_DIV_MORE
  } cond_e;

  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] UPC_IDLE    = 4'd0;
  localparam logic [UPC_W-1:0] UPC_CHECK   = 4'd1;
  localparam logic [UPC_W-1:0] UPC_READ    = 4'd2;
  localparam logic [UPC_W-1:0] UPC_MULA    = 4'd3;
  localparam logic [UPC_W-1:0] UPC_MULB    = 4'd4;
  localparam logic [UPC_W-1:0] UPC_ACCUM   = 4'd5;
  localparam logic [UPC_W-1:0] UPC_SCALE   = 4'd6;
  localparam logic [UPC_W-1:0] UPC_DIV_EST = 4'd7;
  localparam logic [UPC_W-1:0] UPC_DIV_REM = 4'd8;
  localparam logic [UPC_W-1:0] UPC_FINISH  = 4'd9;

  typedef struct packed {
    uop_e             op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic idx_end;
    logic div_more;
  } acq_status_t;

  // Microprogram: one control word per step.
  function automatic ctrl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctrl_word_t w;
    w = '{op: OP_NONE, cond: COND_ALWAYS, target: UPC_IDLE};
    unique case (upc)
      UPC_IDLE:    w = '{op: OP_NONE,    cond: COND_NO_START, target: UPC_IDLE};
      UPC_CHECK:   w = '{op: OP_NONE,    cond: COND_IDX_END,  target: UPC_SCALE};
      UPC_READ:    w = '{op: OP_READ,    cond: COND_NEVER,    target: UPC_IDLE};
      UPC_MULA:    w = '{op: OP_MULA,    cond: COND_NEVER,    target: UPC_IDLE};
      UPC_MULB:    w = '{op: OP_MULB,    cond: COND_NEVER,    target: UPC_IDLE};
      UPC_ACCUM:   w = '{op: OP_ACC,     cond: COND_ALWAYS,   target: UPC_CHECK};
      UPC_SCALE:   w = '{op: OP_SCALE,   cond: COND_NEVER,    target: UPC_IDLE};
      UPC_DIV_EST: w = '{op: OP_DIV_EST, cond: COND_NEVER,    target: UPC_IDLE};
      UPC_DIV_REM: w = '{op: OP_DIV_REM, cond: COND_DIV_MORE, target: UPC_DIV_EST};
      UPC_FINISH:  w = '{op: OP_FINISH,  cond: COND_ALWAYS,   target: UPC_IDLE};
      default:     w = '{op: OP_NONE,    cond: COND_ALWAYS,   target: UPC_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[hdl/bbitr_useq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module bbitr_useq (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start_i,
  input  bbitr_pkg::acq_status_t   status_i,
  output bbitr_pkg::ctrl_word_t    ctrl_o,
  output logic                     idle_o
);
  import bbitr_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  ctrl_word_t       word;
  logic             taken;

  // Fetch the control word of the current step.
  assign word   = ucode_rom(upc_q);
  assign ctrl_o = word;
  assign idle_o = (upc_q == UPC_IDLE);

  // Evaluate the jump condition.
  always_comb begin
    unique case (word.cond)
      COND_NEVER:    taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_START: taken = !start_i;
      COND_IDX_END:  taken = status_i.idx_end;
      COND_DIV_MORE: taken = status_i.div_more;
      default:       taken = 1'b1;
    endcase
  end

  assign upc_d = taken ? word.target : upc_q + UPC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

`default_nettype wire

[hdl/bbitr_acq_dp.sv]
// Acquisition datapath: channel table, multiply chain, accumulator and reciprocal divider.
`default_nettype none

module bbitr_acq_dp #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire  [4:0]               channel_i,
  input  wire  [2:0]               config_word_i,
  input  wire  [31:0]              write_data_i,
  input  wire                      start_i,
  input  wire  [5:0]               channel_count_i,
  input  bbitr_pkg::ctrl_word_t    ctrl_i,
  output bbitr_pkg::acq_status_t   status_o,
  output logic [31:0]              acq_time_o
);
  import bbitr_pkg::*;

  localparam int unsigned AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CW = $clog2(MAX_CHANNELS + 1);
  localparam logic [7:0]  MaxCh = 8'(MAX_CHANNELS);
  localparam int unsigned LO_W = 19;
  localparam int unsigned SP_W = 5;

  // Channel table, split so that each configuration word writes a whole entry.
  logic [LO_W-1:0]         lo_mem [MAX_CHANNELS];
  logic [SP_W-1:0]         sp_mem [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] lo_vld_q, sp_vld_q;
  logic [LO_W-1:0]         lo_rd_q;
  logic [SP_W-1:0]         sp_rd_q;
  logic                    lo_rd_vld_q, sp_rd_vld_q;

  logic [7:0]    ch_ext;
  logic          ch_ok, lo_we, sp_we;
  logic [AW-1:0] wr_addr, rd_addr;

  logic [7:0]           cnt_ext, cnt_sat;
  logic [CW-1:0]        n_q, n_d, idx_q, idx_d;
  logic [ACC_W-1:0]     acc_q, acc_d;
  logic [P1_W-1:0]      p1_q, p1_d;
  logic [P2_W-1:0]      p2_q, p2_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [NUM_W-1:0]     num_q, num_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIG_W-1:0]     dig_q, dig_d;
  logic [DIG_CNT_W-1:0] dig_cnt_q, dig_cnt_d;

  logic [LO_W-1:0]   lo_ent;
  logic [SP_W-1:0]   sp_ent;
  logic [T_W-1:0]    t_val;
  logic [PART_W-1:0] dvd_part, rem_full;
  logic [EST_W-1:0]  est;

  assign ch_ext  = {3'b000, channel_i};
  assign ch_ok   = (ch_ext < MaxCh);
  assign lo_we   = cfg_we_i && ch_ok && (config_word_i == CFG_WORD_CODE);
  assign sp_we   = cfg_we_i && ch_ok && (config_word_i == CFG_WORD_SPAN);
  assign wr_addr = ch_ext[AW-1:0];
  assign rd_addr = idx_q[AW-1:0];

  // Table writes and registered reads.
  always_ff @(posedge clk_i) begin
    if (lo_we) begin
      lo_mem[wr_addr] <= {write_data_i[22:16], write_data_i[13:8], write_data_i[5:0]};
    end
    if (sp_we) begin
      sp_mem[wr_addr] <= write_data_i[4:0];
    end
    if (ctrl_i.op == OP_READ) begin
      lo_rd_q <= lo_mem[rd_addr];
      sp_rd_q <= sp_mem[rd_addr];
    end
  end

  // Valid bits: an entry never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_vld_q    <= '0;
      sp_vld_q    <= '0;
      lo_rd_vld_q <= 1'b0;
      sp_rd_vld_q <= 1'b0;
    end else begin
      if (lo_we) begin
        lo_vld_q[wr_addr] <= 1'b1;
      end
      if (sp_we) begin
        sp_vld_q[wr_addr] <= 1'b1;
      end
      if (ctrl_i.op == OP_READ) begin
        lo_rd_vld_q <= lo_vld_q[rd_addr];
        sp_rd_vld_q <= sp_vld_q[rd_addr];
      end
    end
  end

  assign lo_ent = lo_rd_vld_q ? lo_rd_q : '0;
  assign sp_ent = sp_rd_vld_q ? sp_rd_q : '0;

  // Channel count saturates at the table depth.
  assign cnt_ext = {2'b00, channel_count_i};
  assign cnt_sat = (cnt_ext > MaxCh) ? MaxCh : cnt_ext;

  // One plus six times the coherent product, by shift and add.
  assign t_val = T_W'({p1_q, 2'b00}) + T_W'({p1_q, 1'b0}) + T_W'(1);

  // Quotient digit estimate by reciprocal multiplication, then the new remainder.
  assign dvd_part = {rem_q, num_q[NUM_W-1 -: DIG_W]};
  assign est      = EST_W'(dvd_part) * EST_W'(RECIP);
  assign rem_full = dvd_part - PART_W'(dig_q) * PART_W'(CLK_PER_BLOCK);

  // Datapath next values selected by the micro-operation.
  always_comb begin
    n_d       = n_q;
    idx_d     = idx_q;
    acc_d     = acc_q;
    p1_d      = p1_q;
    p2_d      = p2_q;
    prod_d    = prod_q;
    num_d     = num_q;
    rem_d     = rem_q;
    dig_d     = dig_q;
    dig_cnt_d = dig_cnt_q;
    if (start_i) begin
      n_d   = cnt_sat[CW-1:0];
      idx_d = '0;
      acc_d = ACC_W'(2);
    end
    unique case (ctrl_i.op)
      OP_MULA: begin
        p1_d = P1_W'(lo_ent[11:6]) * P1_W'(lo_ent[18:12]);
        p2_d = P2_W'(lo_ent[5:0]) * P2_W'(sp_ent);
      end
      OP_MULB: prod_d = PROD_W'(p2_q) * PROD_W'(t_val);
      OP_ACC: begin
        acc_d = acc_q + ACC_W'(prod_q);
        idx_d = idx_q + CW'(1);
      end
      OP_SCALE: begin
        num_d     = NUM_W'(acc_q) * NUM_W'(CYC_PER_UNIT);
        rem_d     = '0;
        dig_cnt_d = '0;
      end
      OP_DIV_EST: dig_d = est[RECIP_SH +: DIG_W];
      OP_DIV_REM: begin
        rem_d     = rem_full[DIV_W-1:0];
        num_d     = {num_q[NUM_W-DIG_W-1:0], dig_q};
        dig_cnt_d = dig_cnt_q + DIG_CNT_W'(1);
      end
      OP_NONE, OP_READ, OP_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    n_q       <= n_d;
    idx_q     <= idx_d;
    acc_q     <= acc_d;
    p1_q      <= p1_d;
    p2_q      <= p2_d;
    prod_q    <= prod_d;
    num_q     <= num_d;
    rem_q     <= rem_d;
    dig_q     <= dig_d;
    dig_cnt_q <= dig_cnt_d;
  end

  assign status_o.idx_end  = (idx_q == n_q);
  assign status_o.div_more = (dig_cnt_q != DIG_LAST);
  assign acq_time_o        = num_q[31:0] + 32'd1;

endmodule

`default_nettype wire

[hdl/baseband_interrupt_and_timing_regs.sv]
// Top level of the baseband global register and interrupt block.
`default_nettype none

// Each input beat carries one event and yields one result beat (read data and
// interrupt line). Register writes, reads, channel configuration writes, block
// ticks and unknown kinds load their result beat on acceptance, and the next
// beat is accepted in the following cycle provided the output register is empty
// or is read in that cycle. An acquisition start runs a microcoded sequencer
// over the channel count saturated to MAX_CHANNELS: per channel it steps through
// the loop check, the table read, the two multiply steps and the accumulate,
// then a final check, one scaling step and five quotient digits, each an estimate
// step (a reciprocal multiply for the digit) then a remainder step, for the divide
// by the clocks per block, and one step to load the result. No input is accepted
// until that result is loaded. The channel table needs no clearing pass;
// per-entry valid bits make unwritten entries read zero.
module baseband_interrupt_and_timing_regs #(
  parameter int unsigned MAX_CHANNELS = 32
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  kind_i,
  input  wire  [3:0]  reg_select_i,
  input  wire  [4:0]  channel_i,
  input  wire  [2:0]  config_word_i,
  input  wire  [31:0] write_data_i,
  input  wire  [5:0]  channel_count_i,
  input  wire         track_done_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [31:0] read_data_o,
  output logic        irq_o
);
  import bbitr_pkg::*;

  logic        en_q, en_d;
  logic [9:0]  period_q, period_d;
  logic [9:0]  mcnt_q, mcnt_d;
  logic [9:0]  req_q, req_d;
  logic [31:0] acq_q, acq_d;
  logic [3:0]  flags_q, flags_d;
  logic [31:0] mask_q, mask_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] read_data_q;
  logic        irq_q;
  logic [31:0] rdata;
  logic        irq_d;

  logic        in_acc, seq_idle, acq_start, cfg_we, finish, out_load;
  ctrl_word_t  ctrl;
  acq_status_t status;
  logic [31:0] acq_time;

  logic [9:0]  mcnt_inc, req_dec;
  logic [31:0] acq_dec;

  // Handshake: one event at a time, output slot must be free or freeing.
  assign in_ready_o = seq_idle && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;
  assign acq_start  = in_acc && (kind_i == KIND_ACQ_START);
  assign cfg_we     = in_acc && (kind_i == KIND_CFG_WRITE);
  assign finish     = (ctrl.op == OP_FINISH);

  bbitr_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (acq_start),
    .status_i (status),
    .ctrl_o   (ctrl),
    .idle_o   (seq_idle)
  );

  bbitr_acq_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_acq_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .channel_i       (channel_i),
    .config_word_i   (config_word_i),
    .write_data_i    (write_data_i),
    .start_i         (acq_start),
    .channel_count_i (channel_count_i),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .acq_time_o      (acq_time)
  );

  // Register file update for accepted events and for the acquisition result.
  always_comb begin
    en_d     = en_q;
    period_d = period_q;
    mcnt_d   = mcnt_q;
    req_d    = req_q;
    acq_d    = acq_q;
    flags_d  = flags_q;
    mask_d   = mask_q;
    rdata    = 32'd0;
    mcnt_inc = mcnt_q + 10'd1;
    req_dec  = req_q - 10'd1;
    acq_dec  = acq_q - 32'd1;
    if (in_acc) begin
      unique case (kind_i)
        KIND_GWRITE: begin
          unique case (reg_select_i)
            REG_ENABLE:     if (write_data_i[8]) en_d = 1'b1;
            REG_MEAS_NUM:   period_d = write_data_i[9:0];
            REG_MEAS_COUNT: mcnt_d = write_data_i[9:0];
            REG_FLAGS:      flags_d = flags_q & ~write_data_i[11:8];
            REG_REQUEST:    req_d = write_data_i[9:0];
            REG_MASK:       mask_d = write_data_i;
            default: ;
          endcase
        end
        KIND_GREAD: begin
          unique case (reg_select_i)
            REG_ENABLE:     rdata = {23'd0, en_q, 8'd0};
            REG_MEAS_NUM:   rdata = {22'd0, period_q};
            REG_MEAS_COUNT: rdata = {22'd0, mcnt_q};
            REG_FLAGS:      rdata = {20'd0, flags_q, 8'd0};
            REG_REQUEST:    rdata = {22'd0, req_q};
            REG_MASK:       rdata = mask_q;
            default:        rdata = 32'd0;
          endcase
        end
        KIND_TICK: begin
          if (en_q) begin
            if (track_done_i) flags_d[FLAG_TRACK] = 1'b1;
            if (mcnt_inc == period_q) begin
              mcnt_d = 10'd0;
              flags_d[FLAG_MEAS] = 1'b1;
            end else begin
              mcnt_d = mcnt_inc;
            end
          end
          if (req_q != 10'd0) begin
            req_d = req_dec;
            if (req_dec == 10'd0) flags_d[FLAG_REQ] = 1'b1;
          end
          if (acq_q != 32'd0) begin
            acq_d = acq_dec;
            if (acq_dec == 32'd0) flags_d[FLAG_ACQ] = 1'b1;
          end
        end
        default: ;
      endcase
    end
    // Acquisition result loads the countdown.
    if (finish) begin
      acq_d = acq_time;
    end
  end

  assign irq_d = |(flags_d & mask_d[11:8]);

  // Result beat: one per event, acquisition start delivers at its last step.
  assign out_load    = (in_acc && (kind_i != KIND_ACQ_START)) || finish;
  assign out_valid_d = out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q        <= 1'b0;
      period_q    <= '0;
      mcnt_q      <= '0;
      req_q       <= '0;
      acq_q       <= '0;
      flags_q     <= '0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      en_q        <= en_d;
      period_q    <= period_d;
      mcnt_q      <= mcnt_d;
      req_q       <= req_d;
      acq_q       <= acq_d;
      flags_q     <= flags_d;
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      read_data_q <= rdata;
      irq_q       <= irq_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign irq_o       = irq_q;

  // The acquisition result never lands on an occupied output slot.
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |-> !out_valid_q)
    else $error("acquisition result overwrote a pending result beat");

  // Acquisition start blocks further input on the next cycle.
  a_acq_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acq_start |=> !in_ready_o)
    else $error("input accepted during acquisition computation");

  // A result beat appears only after an accepted event or a finished acquisition.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(out_load))
    else $error("result beat without a source event");

  // The sequencer only leaves idle on an acquisition start.
  a_seq_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_idle && !acq_start) |=> seq_idle)
    else $error("sequencer left idle without a start");

endmodule

`default_nettype wire
